// ===== rtl/core/imhq_pkg.sv =====
// shared types, sizes and codes for the indexed min-heap queue
package imhq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int TAG_COUNT  = 1024;
    localparam int KEY_BITS   = 16;

    localparam int SLOT_W = $clog2(HEAP_DEPTH + 1);
    localparam int TAG_W  = $clog2(TAG_COUNT);
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [TAG_W-1:0]    t_tag;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STAT_W-1:0]   t_status;

    typedef struct packed {
        t_tag tag;
        t_key key;
    } t_entry;

    // heap memory port request
    typedef struct packed {
        logic   we;
        t_slot  waddr;
        t_entry wdata;
        t_slot  raddr;
    } t_heap_req;

    // position table port request
    typedef struct packed {
        logic  we;
        t_tag  waddr;
        t_slot wdata;
        t_tag  raddr;
    } t_pos_req;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_POP    = 2'd1;
    localparam t_cmd CMD_UPDATE = 2'd2;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_EMPTY   = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_ABSENT  = 3'd3;
    localparam t_status ST_PRESENT = 3'd4;

endpackage

// ===== rtl/core/imhq_cmd_if.sv =====
// command channel: valid, ready and one command word
interface imhq_cmd_if;
    import imhq_pkg::*;
    logic valid;
    logic ready;
    t_cmd cmd;
    t_tag node_tag;
    t_key key;
    modport source (output valid, output cmd, output node_tag, output key, input ready);
    modport sink   (input valid, input cmd, input node_tag, input key, output ready);
endinterface

// ===== rtl/core/imhq_rsp_if.sv =====
// result channel: valid, ready and one result word
interface imhq_rsp_if;
    import imhq_pkg::*;
    logic           valid;
    logic           ready;
    t_status        status;
    t_tag           out_tag;
    t_key           out_key;
    logic [8:0]     occupancy;
    modport source (output valid, output status, output out_tag, output out_key,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_tag, input out_key,
                    input occupancy, output ready);
endinterface

// ===== rtl/core/imhq_heap_mem.sv =====
// heap slot memory: tag and key per slot, one write and one registered read
module imhq_heap_mem
    import imhq_pkg::*;
(
    input  logic      i_clk,
    input  t_heap_req i_req,
    output t_entry    o_rdata
);

    t_entry r_mem [HEAP_DEPTH+1];
    t_entry r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/imhq_pos_mem.sv =====
// tag to slot position table, one write and one registered read
module imhq_pos_mem
    import imhq_pkg::*;
(
    input  logic     i_clk,
    input  t_pos_req i_req,
    output t_slot    o_rdata
);

    t_slot r_mem [TAG_COUNT];
    t_slot r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/imhq_ctrl.sv =====
// sequencer: command decode, sift up and sift down over the two memories
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    imhq_cmd_if.sink    i_cmd,
    imhq_rsp_if.source  o_rsp,
    output t_heap_req   o_heap_req,
    input  t_entry      i_heap_rdata,
    output t_pos_req    o_pos_req,
    input  t_slot       i_pos_rdata
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_UP    = 4'd4;
    localparam logic [3:0] S_UPC   = 4'd5;
    localparam logic [3:0] S_DOWN  = 4'd6;
    localparam logic [3:0] S_DL    = 4'd7;
    localparam logic [3:0] S_DR    = 4'd8;
    localparam logic [3:0] S_PLACE = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam t_tag  TAG_LAST = t_tag'(TAG_COUNT - 1);
    localparam t_slot SLOT_MAX = t_slot'(HEAP_DEPTH);

    logic [3:0] r_state, n_state;
    t_tag       r_clr, n_clr;
    t_cmd       r_cmd, n_cmd;
    t_tag       r_mtag, n_mtag;
    t_key       r_mkey, n_mkey;
    t_slot      r_hole, n_hole;
    t_slot      r_cnt, n_cnt;
    logic       r_down, n_down;
    t_slot      r_bslot, n_bslot;
    t_tag       r_btag, n_btag;
    t_key       r_bkey, n_bkey;
    t_status    r_status, n_status;
    t_tag       r_otag, n_otag;
    t_key       r_okey, n_okey;
    logic       r_ov, n_ov;
    t_status    r_o_status, n_o_status;
    t_tag       r_o_tag, n_o_tag;
    t_key       r_o_key, n_o_key;
    t_slot      r_o_occ, n_o_occ;

    logic            present;
    logic [SLOT_W:0] lchild;
    logic [SLOT_W:0] rchild;
    t_slot           d_slot;
    t_tag            d_tag;
    t_key            d_key;
    logic            out_free;

    assign present  = (i_pos_rdata != '0) && (i_pos_rdata <= r_cnt);
    assign lchild   = {r_hole, 1'b0};
    assign rchild   = lchild + 1'b1;
    assign out_free = !r_ov || o_rsp.ready;

    // best of hole and children seen so far
    always_comb begin
        d_slot = r_hole;
        d_tag  = r_mtag;
        d_key  = r_mkey;
        if (r_state == S_DL) begin
            if (r_mkey >= i_heap_rdata.key) begin
                d_slot = lchild[SLOT_W-1:0];
                d_tag  = i_heap_rdata.tag;
                d_key  = i_heap_rdata.key;
            end
        end else begin
            d_slot = r_bslot;
            d_tag  = r_btag;
            d_key  = r_bkey;
            if (r_bkey >= i_heap_rdata.key) begin
                d_slot = rchild[SLOT_W-1:0];
                d_tag  = i_heap_rdata.tag;
                d_key  = i_heap_rdata.key;
            end
        end
    end

    // next state and memory requests
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        n_mtag     = r_mtag;
        n_mkey     = r_mkey;
        n_hole     = r_hole;
        n_cnt      = r_cnt;
        n_down     = r_down;
        n_bslot    = r_bslot;
        n_btag     = r_btag;
        n_bkey     = r_bkey;
        n_status   = r_status;
        n_otag     = r_otag;
        n_okey     = r_okey;
        n_ov       = r_ov && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_tag    = r_o_tag;
        n_o_key    = r_o_key;
        n_o_occ    = r_o_occ;
        o_heap_req       = '0;
        o_heap_req.raddr = t_slot'(1);
        o_pos_req        = '0;
        o_pos_req.raddr  = i_cmd.node_tag;

        unique case (r_state)
            S_CLEAR: begin
                o_pos_req.we    = 1'b1;
                o_pos_req.waddr = r_clr;
                n_clr           = r_clr + 1'b1;
                if (r_clr == TAG_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.cmd;
                    n_mtag   = i_cmd.node_tag;
                    n_mkey   = i_cmd.key;
                    n_status = ST_OK;
                    n_otag   = '0;
                    n_okey   = '0;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_FIN;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (present) begin
                            n_status = ST_PRESENT;
                        end else if (r_cnt >= SLOT_MAX) begin
                            n_status = ST_FULL;
                        end else begin
                            n_cnt   = r_cnt + 1'b1;
                            n_hole  = r_cnt + 1'b1;
                            n_down  = 1'b0;
                            n_state = S_UP;
                        end
                    end
                    CMD_POP: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_otag           = i_heap_rdata.tag;
                            n_okey           = i_heap_rdata.key;
                            o_pos_req.we     = 1'b1;
                            o_pos_req.waddr  = i_heap_rdata.tag;
                            o_heap_req.raddr = r_cnt;
                            n_state          = S_POP;
                        end
                    end
                    CMD_UPDATE: begin
                        if (!present) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_hole  = i_pos_rdata;
                            n_down  = 1'b1;
                            n_state = S_UP;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_POP: begin
                n_mtag = i_heap_rdata.tag;
                n_mkey = i_heap_rdata.key;
                n_cnt  = r_cnt - 1'b1;
                n_hole = t_slot'(1);
                n_down = 1'b1;
                if (r_cnt > t_slot'(1)) begin
                    n_state = S_DOWN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UP: begin
                o_heap_req.raddr = r_hole >> 1;
                if (r_hole == t_slot'(1)) begin
                    n_state = r_down ? S_DOWN : S_PLACE;
                end else begin
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (r_mkey <= i_heap_rdata.key) begin
                    // parent moves down into the hole
                    o_heap_req.we    = 1'b1;
                    o_heap_req.waddr = r_hole;
                    o_heap_req.wdata = i_heap_rdata;
                    o_pos_req.we     = 1'b1;
                    o_pos_req.waddr  = i_heap_rdata.tag;
                    o_pos_req.wdata  = r_hole;
                    n_hole           = r_hole >> 1;
                    n_state          = S_UP;
                end else begin
                    n_state = r_down ? S_DOWN : S_PLACE;
                end
            end
            S_DOWN: begin
                o_heap_req.raddr = lchild[SLOT_W-1:0];
                if (lchild > {1'b0, r_cnt}) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_DL;
                end
            end
            S_DL, S_DR: begin
                o_heap_req.raddr = rchild[SLOT_W-1:0];
                if (r_state == S_DL && rchild <= {1'b0, r_cnt}) begin
                    n_bslot = d_slot;
                    n_btag  = d_tag;
                    n_bkey  = d_key;
                    n_state = S_DR;
                end else if (d_slot == r_hole) begin
                    n_state = S_PLACE;
                end else begin
                    // smaller child moves up into the hole
                    o_heap_req.we     = 1'b1;
                    o_heap_req.waddr  = r_hole;
                    o_heap_req.wdata  = '{tag: d_tag, key: d_key};
                    o_pos_req.we      = 1'b1;
                    o_pos_req.waddr   = d_tag;
                    o_pos_req.wdata   = r_hole;
                    n_hole            = d_slot;
                    n_state           = S_DOWN;
                end
            end
            S_PLACE: begin
                o_heap_req.we    = 1'b1;
                o_heap_req.waddr = r_hole;
                o_heap_req.wdata = '{tag: r_mtag, key: r_mkey};
                o_pos_req.we     = 1'b1;
                o_pos_req.waddr  = r_mtag;
                o_pos_req.wdata  = r_hole;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_tag    = r_otag;
                    n_o_key    = r_okey;
                    n_o_occ    = r_cnt;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_mtag     <= n_mtag;
        r_mkey     <= n_mkey;
        r_hole     <= n_hole;
        r_down     <= n_down;
        r_bslot    <= n_bslot;
        r_btag     <= n_btag;
        r_bkey     <= n_bkey;
        r_status   <= n_status;
        r_otag     <= n_otag;
        r_okey     <= n_okey;
        r_o_status <= n_o_status;
        r_o_tag    <= n_o_tag;
        r_o_key    <= n_o_key;
        r_o_occ    <= n_o_occ;
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.out_tag   = r_o_tag;
    assign o_rsp.out_key   = r_o_key;
    assign o_rsp.occupancy = r_o_occ;

endmodule

// ===== rtl/core/indexed_min_heap_queue.sv =====
// indexed binary min-heap queue: insert, pop minimum and key update by tag
// steps per command: accept, lookup, placement and result, plus a parent read and compare
// per level on the way up and, on the way down, a step per level plus a read per child;
// pop adds a read of the last entry; a rejected or unused command goes from lookup to result
// throughput: one command at a time, the next accepted once the result word is registered
// reset: synchronous active low; every tag's position entry is then cleared, no command taken until done
module indexed_min_heap_queue
    import imhq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    imhq_cmd_if.sink   i_cmd,
    imhq_rsp_if.source o_rsp
);

    t_heap_req heap_req;
    t_entry    heap_rdata;
    t_pos_req  pos_req;
    t_slot     pos_rdata;

    // heap slots
    imhq_heap_mem u_heap_mem (
        .i_clk   (i_clk),
        .i_req   (heap_req),
        .o_rdata (heap_rdata)
    );

    // tag positions
    imhq_pos_mem u_pos_mem (
        .i_clk   (i_clk),
        .i_req   (pos_req),
        .o_rdata (pos_rdata)
    );

    // command sequencer
    imhq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_rsp        (o_rsp),
        .o_heap_req   (heap_req),
        .i_heap_rdata (heap_rdata),
        .o_pos_req    (pos_req),
        .i_pos_rdata  (pos_rdata)
    );

endmodule
